[hdl/wwfa_pkg.sv]
`default_nettype none
// ============================================================================
// wwfa_pkg
// Shared types, constants and helpers of the Wi-Fi window feature aggregator.
// ============================================================================
package wwfa_pkg;

  localparam int unsigned DefBssidEntries = 8;
  localparam int unsigned DefTwinEntries  = 4;
  localparam int unsigned NumCounters     = 11;

  localparam logic [23:0] WinLenReset = 24'd100000;
  localparam logic [47:0] RogueReset  = 48'h021337000001;

  localparam logic [1:0] RegWinLen = 2'd0;
  localparam logic [1:0] RegOwnAp  = 2'd1;
  localparam logic [1:0] RegRogue  = 2'd2;

  localparam logic [1:0] ClsMgmt = 2'd1;
  localparam logic [1:0] ClsData = 2'd2;
  localparam logic [1:0] ClsCtrl = 2'd3;

  localparam logic [2:0] SubBeacon   = 3'd1;
  localparam logic [2:0] SubDeauth   = 3'd2;
  localparam logic [2:0] SubDisassoc = 3'd3;
  localparam logic [2:0] SubProbe    = 3'd4;
  localparam logic [2:0] SubAuth     = 3'd5;

  localparam int unsigned EcTotal  = 0;
  localparam int unsigned EcBeacon = 1;
  localparam int unsigned EcDeauth = 2;
  localparam int unsigned EcProbe  = 3;
  localparam int unsigned EcAuth   = 4;
  localparam int unsigned EcMgmt   = 5;
  localparam int unsigned EcData   = 6;
  localparam int unsigned EcCtrl   = 7;
  localparam int unsigned EcTarget = 8;
  localparam int unsigned EcJump   = 9;
  localparam int unsigned EcSignal = 10;

  localparam logic [4:0] FeatTotal    = 5'd0;
  localparam logic [4:0] FeatBeacon   = 5'd1;
  localparam logic [4:0] FeatDeauth   = 5'd2;
  localparam logic [4:0] FeatTarget   = 5'd3;
  localparam logic [4:0] FeatProbe    = 5'd4;
  localparam logic [4:0] FeatAuth     = 5'd5;
  localparam logic [4:0] FeatJump     = 5'd6;
  localparam logic [4:0] FeatMgmt     = 5'd7;
  localparam logic [4:0] FeatData     = 5'd8;
  localparam logic [4:0] FeatCtrl     = 5'd9;
  localparam logic [4:0] FeatBytes    = 5'd10;
  localparam logic [4:0] FeatMgmtB    = 5'd11;
  localparam logic [4:0] FeatDataB    = 5'd12;
  localparam logic [4:0] FeatMean     = 5'd13;
  localparam logic [4:0] FeatMaxLen   = 5'd14;
  localparam logic [4:0] FeatLenSum   = 5'd15;
  localparam logic [4:0] FeatRssiSum  = 5'd16;
  localparam logic [4:0] FeatSnrSum   = 5'd17;
  localparam logic [4:0] FeatRssiSq   = 5'd18;
  localparam logic [4:0] FeatBssidCnt = 5'd19;
  localparam logic [4:0] FeatTwinCnt  = 5'd20;
  localparam logic [4:0] FeatRogue    = 5'd21;

  typedef struct packed {
    logic [47:0]       ts;
    logic [15:0]       len;
    logic signed [7:0] rssi;
    logic signed [7:0] snr;
    logic [47:0]       bssid;
    logic              ours;
    logic              mgmt;
    logic              data;
    logic              ctrl;
    logic              beacon;
    logic              deauth;
    logic              probe;
    logic              auth;
    logic              tgt;
    logic              jump;
  } item_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [63:0] sat_adds64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[hdl/wwfa_front.sv]
`default_nettype none
// ============================================================================
// wwfa_front
// Accepts frame records, decodes their class fields and queues them.
// ============================================================================
module wwfa_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [47:0]       timestamp_us,
  input  wire logic [1:0]        frame_class,
  input  wire logic [2:0]        subtype_class,
  input  wire logic [15:0]       frame_length,
  input  wire logic signed [7:0] rssi_dbm,
  input  wire logic signed [7:0] snr_db,
  input  wire logic [47:0]       frame_bssid,
  input  wire logic              ssid_is_ours,
  input  wire logic              targeted_deauth,
  input  wire logic              sequence_jump,
  output logic                   q_valid,
  output wwfa_pkg::item_t        q_item,
  input  wire logic              q_pop
);

  wwfa_pkg::item_t slots [2];
  wwfa_pkg::item_t item_in;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    item_in.ts     = timestamp_us;
    item_in.len    = frame_length;
    item_in.rssi   = rssi_dbm;
    item_in.snr    = snr_db;
    item_in.bssid  = frame_bssid;
    item_in.ours   = ssid_is_ours;
    item_in.mgmt   = (frame_class == wwfa_pkg::ClsMgmt);
    item_in.data   = (frame_class == wwfa_pkg::ClsData);
    item_in.ctrl   = (frame_class == wwfa_pkg::ClsCtrl);
    item_in.beacon = (subtype_class == wwfa_pkg::SubBeacon);
    item_in.deauth = (subtype_class == wwfa_pkg::SubDeauth) ||
                     (subtype_class == wwfa_pkg::SubDisassoc);
    item_in.probe  = (subtype_class == wwfa_pkg::SubProbe);
    item_in.auth   = (subtype_class == wwfa_pkg::SubAuth);
    item_in.tgt    = targeted_deauth;
    item_in.jump   = sequence_jump;
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hdl/wwfa_div.sv]
`default_nettype none
// ============================================================================
// wwfa_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ============================================================================
module wwfa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] dvd;
  logic [31:0] dvs;
  logic [31:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem, dvd[63]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= 32'd0;
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      dvd <= {dvd[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/wwfa_back.sv]
`default_nettype none
// ============================================================================
// wwfa_back
// Accumulates window statistics, tracks the BSSID sets and emits features.
// ============================================================================
module wwfa_back #(
  parameter int unsigned BSSID_ENTRIES = wwfa_pkg::DefBssidEntries,
  parameter int unsigned TWIN_ENTRIES  = wwfa_pkg::DefTwinEntries
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [23:0]        win_len,
  input  wire logic [47:0]        own_ap,
  input  wire logic [47:0]        rogue,
  input  wire logic               q_valid,
  input  wire wwfa_pkg::item_t    q_item,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [4:0]              feature_id,
  output logic signed [63:0]      feature_value,
  output logic                    last_feature
);

  localparam int unsigned MaxE = (BSSID_ENTRIES > TWIN_ENTRIES) ? BSSID_ENTRIES : TWIN_ENTRIES;
  localparam int unsigned IW   = $clog2(MaxE + 1);
  localparam int unsigned SCW  = $clog2(BSSID_ENTRIES + 1);
  localparam int unsigned TCW  = $clog2(TWIN_ENTRIES + 1);
  localparam int unsigned SAW  = (BSSID_ENTRIES > 1) ? $clog2(BSSID_ENTRIES) : 1;
  localparam int unsigned TAW  = (TWIN_ENTRIES > 1) ? $clog2(TWIN_ENTRIES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]       state;
  wwfa_pkg::item_t  it;
  logic [47:0]      window_start;
  logic [31:0]      event_counters [wwfa_pkg::NumCounters];
  logic [31:0]      byte_totals [3];
  logic [63:0]      length_sum;
  logic [15:0]      length_max;
  logic [63:0]      signal_sums [3];
  logic [47:0]      seen_bssids [BSSID_ENTRIES];
  logic [47:0]      twin_bssids [TWIN_ENTRIES];
  logic [SCW-1:0]   seen_bssid_count;
  logic [TCW-1:0]   twin_count;
  logic             rogue_seen;
  logic [47:0]      seen_rd;
  logic [47:0]      twin_rd;
  logic [IW-1:0]    idx;
  logic             seen_hit;
  logic             twin_hit;
  logic             close_win;
  logic [4:0]       fid;
  logic             div_start;
  logic             div_done;
  logic [63:0]      quotient;
  logic [63:0]      mean_dividend;
  logic [64:0]      mean_sum;
  logic [64:0]      len_sum_ext;
  logic [wwfa_pkg::NumCounters-1:0] inc;
  logic signed [15:0] rssi_sq;
  logic             seen_cand;
  logic             twin_cand;
  logic             scan_done;
  logic             seen_ins;
  logic             twin_ins;
  logic [47:0]      ts_diff;

  wwfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mean_dividend),
    .divisor  (event_counters[wwfa_pkg::EcTotal]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    inc                     = '0;
    inc[wwfa_pkg::EcTotal]  = 1'b1;
    inc[wwfa_pkg::EcBeacon] = it.beacon;
    inc[wwfa_pkg::EcDeauth] = it.deauth;
    inc[wwfa_pkg::EcProbe]  = it.probe;
    inc[wwfa_pkg::EcAuth]   = it.auth;
    inc[wwfa_pkg::EcMgmt]   = it.mgmt;
    inc[wwfa_pkg::EcData]   = it.data;
    inc[wwfa_pkg::EcCtrl]   = it.ctrl;
    inc[wwfa_pkg::EcTarget] = it.tgt;
    inc[wwfa_pkg::EcJump]   = it.jump;
    inc[wwfa_pkg::EcSignal] = 1'b1;
  end

  assign rssi_sq       = it.rssi * it.rssi;
  assign len_sum_ext   = {1'b0, length_sum} + {49'd0, it.len};
  assign mean_sum      = {1'b0, length_sum} + {34'd0, event_counters[wwfa_pkg::EcTotal][31:1]};
  assign mean_dividend = mean_sum[64] ? '1 : mean_sum[63:0];
  assign seen_cand     = (it.bssid != 48'd0);
  assign twin_cand     = seen_cand && it.ours && (own_ap != 48'd0) && (it.bssid != own_ap);
  assign scan_done     = (idx >= IW'(seen_bssid_count)) && (idx >= IW'(twin_count));
  assign seen_ins      = seen_cand && !seen_hit && (seen_bssid_count < SCW'(BSSID_ENTRIES));
  assign twin_ins      = twin_cand && !twin_hit && (twin_count < TCW'(TWIN_ENTRIES));
  assign ts_diff       = it.ts - window_start;
  assign div_start     = (state == S_INS) && close_win;
  assign q_pop         = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      seen_rd <= seen_bssids[idx[SAW-1:0]];
      twin_rd <= twin_bssids[idx[TAW-1:0]];
    end
    if (state == S_INS && seen_ins) begin
      seen_bssids[seen_bssid_count[SAW-1:0]] <= it.bssid;
    end
    if (state == S_INS && twin_ins) begin
      twin_bssids[twin_count[TAW-1:0]] <= it.bssid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window_start     <= 48'd0;
      event_counters   <= '{default: 32'd0};
      byte_totals      <= '{default: 32'd0};
      length_sum       <= 64'd0;
      length_max       <= 16'd0;
      signal_sums      <= '{default: 64'd0};
      seen_bssid_count <= '0;
      twin_count       <= '0;
      rogue_seen       <= 1'b0;
      idx              <= '0;
      seen_hit         <= 1'b0;
      twin_hit         <= 1'b0;
      close_win        <= 1'b0;
      fid              <= 5'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx      <= '0;
            seen_hit <= 1'b0;
            twin_hit <= 1'b0;
            state    <= S_ACC;
          end
        end
        S_ACC: begin
          for (int i = 0; i < wwfa_pkg::NumCounters; i++) begin
            event_counters[i] <= wwfa_pkg::sat_add32(event_counters[i], {31'd0, inc[i]});
          end
          byte_totals[0] <= wwfa_pkg::sat_add32(byte_totals[0], {16'd0, it.len});
          if (it.mgmt) begin
            byte_totals[1] <= wwfa_pkg::sat_add32(byte_totals[1], {16'd0, it.len});
          end
          if (it.data) begin
            byte_totals[2] <= wwfa_pkg::sat_add32(byte_totals[2], {16'd0, it.len});
          end
          length_sum <= len_sum_ext[64] ? '1 : len_sum_ext[63:0];
          if (it.len > length_max) begin
            length_max <= it.len;
          end
          signal_sums[0] <= wwfa_pkg::sat_adds64(signal_sums[0], {{56{it.rssi[7]}}, it.rssi});
          signal_sums[1] <= wwfa_pkg::sat_adds64(signal_sums[1], {{56{it.snr[7]}}, it.snr});
          signal_sums[2] <= wwfa_pkg::sat_adds64(signal_sums[2], {{48{rssi_sq[15]}}, rssi_sq});
          if (it.bssid == rogue) begin
            rogue_seen <= 1'b1;
          end
          close_win <= (it.ts >= window_start) && (ts_diff >= {24'd0, win_len});
          state     <= S_RD;
        end
        S_RD: begin
          state <= scan_done ? S_INS : S_CMP;
        end
        S_CMP: begin
          if (idx < IW'(seen_bssid_count) && seen_rd == it.bssid) begin
            seen_hit <= 1'b1;
          end
          if (idx < IW'(twin_count) && twin_rd == it.bssid) begin
            twin_hit <= 1'b1;
          end
          idx   <= idx + IW'(1);
          state <= S_RD;
        end
        S_INS: begin
          if (seen_ins) begin
            seen_bssid_count <= seen_bssid_count + SCW'(1);
          end
          if (twin_ins) begin
            twin_count <= twin_count + TCW'(1);
          end
          state <= close_win ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            fid   <= 5'd0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            if (fid == wwfa_pkg::FeatRogue) begin
              window_start     <= it.ts;
              event_counters   <= '{default: 32'd0};
              byte_totals      <= '{default: 32'd0};
              length_sum       <= 64'd0;
              length_max       <= 16'd0;
              signal_sums      <= '{default: 64'd0};
              seen_bssid_count <= '0;
              twin_count       <= '0;
              rogue_seen       <= 1'b0;
              state            <= S_IDLE;
            end else begin
              fid <= fid + 5'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty        = (state != S_EMIT);
  assign feature_id   = fid;
  assign last_feature = (fid == wwfa_pkg::FeatRogue);

  always_comb begin
    unique case (fid)
      wwfa_pkg::FeatTotal:    feature_value = {32'd0, event_counters[wwfa_pkg::EcTotal]};
      wwfa_pkg::FeatBeacon:   feature_value = {32'd0, event_counters[wwfa_pkg::EcBeacon]};
      wwfa_pkg::FeatDeauth:   feature_value = {32'd0, event_counters[wwfa_pkg::EcDeauth]};
      wwfa_pkg::FeatTarget:   feature_value = {32'd0, event_counters[wwfa_pkg::EcTarget]};
      wwfa_pkg::FeatProbe:    feature_value = {32'd0, event_counters[wwfa_pkg::EcProbe]};
      wwfa_pkg::FeatAuth:     feature_value = {32'd0, event_counters[wwfa_pkg::EcAuth]};
      wwfa_pkg::FeatJump:     feature_value = {32'd0, event_counters[wwfa_pkg::EcJump]};
      wwfa_pkg::FeatMgmt:     feature_value = {32'd0, event_counters[wwfa_pkg::EcMgmt]};
      wwfa_pkg::FeatData:     feature_value = {32'd0, event_counters[wwfa_pkg::EcData]};
      wwfa_pkg::FeatCtrl:     feature_value = {32'd0, event_counters[wwfa_pkg::EcCtrl]};
      wwfa_pkg::FeatBytes:    feature_value = {32'd0, byte_totals[0]};
      wwfa_pkg::FeatMgmtB:    feature_value = {32'd0, byte_totals[1]};
      wwfa_pkg::FeatDataB:    feature_value = {32'd0, byte_totals[2]};
      wwfa_pkg::FeatMean:     feature_value = quotient;
      wwfa_pkg::FeatMaxLen:   feature_value = {48'd0, length_max};
      wwfa_pkg::FeatLenSum:   feature_value = length_sum;
      wwfa_pkg::FeatRssiSum:  feature_value = signal_sums[0];
      wwfa_pkg::FeatSnrSum:   feature_value = signal_sums[1];
      wwfa_pkg::FeatRssiSq:   feature_value = signal_sums[2];
      wwfa_pkg::FeatBssidCnt: feature_value = 64'(seen_bssid_count);
      wwfa_pkg::FeatTwinCnt:  feature_value = 64'(twin_count);
      wwfa_pkg::FeatRogue:    feature_value = {63'd0, rogue_seen};
      default:                feature_value = 64'd0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/wifi_window_feature_aggregator_top.sv]
`default_nettype none
// ============================================================================
// wifi_window_feature_aggregator_top
// Tumbling-window feature aggregator for classified Wi-Fi frame records.
// ============================================================================
//  Channel   Handshake                   Payload
//  input     push / full                 timestamp_us .. sequence_jump
//  result    pop / empty                 feature_id, feature_value, last_feature
//  config    psel penable pwrite pready  paddr[4:0], pwdata/prdata 64 bits
//
// In the back end a frame passes through accumulation, a scan of the BSSID
// memories up to the larger of the seen and twin counts, one entry at a time
// with a read and a compare step each, and an insert step. A closing frame
// adds a wait on the divider for the mean length, then 22 result transactions.
// A two-entry queue accepts frames while results wait to be popped, until full.
// Reset is synchronous and clears all counters, sums and set counts.
// ============================================================================
module wifi_window_feature_aggregator_top #(
  parameter int unsigned BSSID_ENTRIES = wwfa_pkg::DefBssidEntries,
  parameter int unsigned TWIN_ENTRIES  = wwfa_pkg::DefTwinEntries
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [47:0]       timestamp_us,
  input  wire logic [1:0]        frame_class,
  input  wire logic [2:0]        subtype_class,
  input  wire logic [15:0]       frame_length,
  input  wire logic signed [7:0] rssi_dbm,
  input  wire logic signed [7:0] snr_db,
  input  wire logic [47:0]       frame_bssid,
  input  wire logic              ssid_is_ours,
  input  wire logic              targeted_deauth,
  input  wire logic              sequence_jump,
  output logic                   empty,
  input  wire logic              pop,
  output logic [4:0]             feature_id,
  output logic signed [63:0]     feature_value,
  output logic                   last_feature,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  logic [23:0]     window_length_us;
  logic [47:0]     own_ap_bssid;
  logic [47:0]     rogue_bssid;
  logic            q_valid;
  logic            q_pop;
  wwfa_pkg::item_t q_item;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_us <= wwfa_pkg::WinLenReset;
      own_ap_bssid     <= 48'd0;
      rogue_bssid      <= wwfa_pkg::RogueReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        wwfa_pkg::RegWinLen: window_length_us <= pwdata[23:0];
        wwfa_pkg::RegOwnAp:  own_ap_bssid     <= pwdata[47:0];
        wwfa_pkg::RegRogue:  rogue_bssid      <= pwdata[47:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wwfa_pkg::RegWinLen: prdata = {40'd0, window_length_us};
      wwfa_pkg::RegOwnAp:  prdata = {16'd0, own_ap_bssid};
      wwfa_pkg::RegRogue:  prdata = {16'd0, rogue_bssid};
      default:             prdata = 64'd0;
    endcase
  end

  wwfa_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .timestamp_us    (timestamp_us),
    .frame_class     (frame_class),
    .subtype_class   (subtype_class),
    .frame_length    (frame_length),
    .rssi_dbm        (rssi_dbm),
    .snr_db          (snr_db),
    .frame_bssid     (frame_bssid),
    .ssid_is_ours    (ssid_is_ours),
    .targeted_deauth (targeted_deauth),
    .sequence_jump   (sequence_jump),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  wwfa_back #(
    .BSSID_ENTRIES (BSSID_ENTRIES),
    .TWIN_ENTRIES  (TWIN_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .win_len       (window_length_us),
    .own_ap        (own_ap_bssid),
    .rogue         (rogue_bssid),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .feature_id    (feature_id),
    .feature_value (feature_value),
    .last_feature  (last_feature)
  );

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_feature == (feature_id == wwfa_pkg::FeatRogue)))
    else $error("last_feature does not match the final feature");

  a_ids_in_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_feature) |=>
      (!empty && feature_id == $past(feature_id) + 5'd1))
    else $error("feature sequence broken");

  a_first_is_zero: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> (feature_id == wwfa_pkg::FeatTotal))
    else $error("window results do not start at the first feature");

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for the Wi-Fi window feature aggregator
// Frame records go into the block through its push/full queue side. An
// in-bench model of the window features predicts the 22 features of every
// closing frame. Each popped result transaction is compared with the oldest
// prediction. A short directed table is followed by random phases under
// several register settings and several idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [4:0] AddrWinLen = {wwfa_pkg::RegWinLen, 3'b000};
  localparam logic [4:0] AddrOwnAp  = {wwfa_pkg::RegOwnAp, 3'b000};
  localparam logic [4:0] AddrRogue  = {wwfa_pkg::RegRogue, 3'b000};
  localparam int         NumFeat    = 22;

  typedef struct packed {
    logic [47:0]       ts;
    logic [1:0]        cls;
    logic [2:0]        sub;
    logic [15:0]       len;
    logic signed [7:0] rssi;
    logic signed [7:0] snr;
    logic [47:0]       bssid;
    logic              ours;
    logic              tgt;
    logic              jump;
  } frame_t;

  typedef struct {
    frame_t      f;
    bit          closes;
    logic [31:0] frames;
  } row_t;

  typedef struct {
    logic [4:0]  id;
    logic [63:0] value;
    logic        last;
  } feature_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [47:0] timestamp_us = '0;
  logic [1:0] frame_class = '0;
  logic [2:0] subtype_class = '0;
  logic [15:0] frame_length = '0;
  logic signed [7:0] rssi_dbm = '0;
  logic signed [7:0] snr_db = '0;
  logic [47:0] frame_bssid = '0;
  logic ssid_is_ours = 1'b0;
  logic targeted_deauth = 1'b0;
  logic sequence_jump = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [4:0] feature_id;
  logic signed [63:0] feature_value;
  logic last_feature;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  wifi_window_feature_aggregator_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  logic [23:0] win_len = wwfa_pkg::WinLenReset;
  logic [47:0] own_ap = '0;
  logic [47:0] rogue_id = wwfa_pkg::RogueReset;
  logic [47:0] win_start = '0;
  logic [31:0] counters [wwfa_pkg::NumCounters];
  logic [31:0] bytes_all, bytes_mgmt, bytes_data;
  logic [63:0] len_sum;
  logic [15:0] len_max;
  logic signed [63:0] rssi_sum, snr_sum, rssi_sq_sum;
  logic [47:0] seen_set [8];
  logic [47:0] twin_set [8];
  int seen_cnt, twin_cnt;
  logic rogue_hit;

  feature_t feature_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [47:0] bssid_pool [12];

  function automatic logic [31:0] add_sat_u32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic signed [63:0] add_sat_s64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  task automatic clear_window_state();
    foreach (counters[i]) counters[i] = '0;
    bytes_all = '0;
    bytes_mgmt = '0;
    bytes_data = '0;
    len_sum = '0;
    len_max = '0;
    rssi_sum = '0;
    snr_sum = '0;
    rssi_sq_sum = '0;
    seen_cnt = 0;
    twin_cnt = 0;
    rogue_hit = 1'b0;
  endtask

  task automatic note_bssid(input logic [47:0] mac, input int cap,
                            inout logic [47:0] set [8], inout int cnt);
    if (mac == '0) return;
    for (int i = 0; i < cnt; i++) if (set[i] == mac) return;
    if (cnt < cap) begin
      set[cnt] = mac;
      cnt++;
    end
  endtask

  task automatic count_frame(input frame_t f, output bit closed);
    logic signed [63:0] r, s;
    logic [63:0] total, half, mean;
    logic [63:0] vals [NumFeat];
    feature_t ft;
    r = f.rssi;
    s = f.snr;
    counters[wwfa_pkg::EcTotal] = add_sat_u32(counters[wwfa_pkg::EcTotal], 32'd1);
    note_bssid(f.bssid, wwfa_pkg::DefBssidEntries, seen_set, seen_cnt);
    if (f.bssid == rogue_id) rogue_hit = 1'b1;
    if (f.ours && own_ap != '0 && f.bssid != own_ap)
      note_bssid(f.bssid, wwfa_pkg::DefTwinEntries, twin_set, twin_cnt);
    unique case (f.cls)
      wwfa_pkg::ClsMgmt: begin
        counters[wwfa_pkg::EcMgmt] = add_sat_u32(counters[wwfa_pkg::EcMgmt], 32'd1);
        bytes_mgmt = add_sat_u32(bytes_mgmt, 32'(f.len));
      end
      wwfa_pkg::ClsData: begin
        counters[wwfa_pkg::EcData] = add_sat_u32(counters[wwfa_pkg::EcData], 32'd1);
        bytes_data = add_sat_u32(bytes_data, 32'(f.len));
      end
      wwfa_pkg::ClsCtrl: begin
        counters[wwfa_pkg::EcCtrl] = add_sat_u32(counters[wwfa_pkg::EcCtrl], 32'd1);
      end
      default: ;
    endcase
    bytes_all = add_sat_u32(bytes_all, 32'(f.len));
    len_sum = (len_sum + 64'(f.len) < len_sum) ? '1 : len_sum + 64'(f.len);
    if (f.len > len_max) len_max = f.len;
    rssi_sum = add_sat_s64(rssi_sum, r);
    snr_sum = add_sat_s64(snr_sum, s);
    rssi_sq_sum = add_sat_s64(rssi_sq_sum, r * r);
    counters[wwfa_pkg::EcSignal] = add_sat_u32(counters[wwfa_pkg::EcSignal], 32'd1);
    unique case (f.sub)
      wwfa_pkg::SubBeacon:
        counters[wwfa_pkg::EcBeacon] = add_sat_u32(counters[wwfa_pkg::EcBeacon], 32'd1);
      wwfa_pkg::SubDeauth, wwfa_pkg::SubDisassoc:
        counters[wwfa_pkg::EcDeauth] = add_sat_u32(counters[wwfa_pkg::EcDeauth], 32'd1);
      wwfa_pkg::SubProbe:
        counters[wwfa_pkg::EcProbe] = add_sat_u32(counters[wwfa_pkg::EcProbe], 32'd1);
      wwfa_pkg::SubAuth:
        counters[wwfa_pkg::EcAuth] = add_sat_u32(counters[wwfa_pkg::EcAuth], 32'd1);
      default: ;
    endcase
    if (f.tgt)
      counters[wwfa_pkg::EcTarget] = add_sat_u32(counters[wwfa_pkg::EcTarget], 32'd1);
    if (f.jump)
      counters[wwfa_pkg::EcJump] = add_sat_u32(counters[wwfa_pkg::EcJump], 32'd1);

    closed = !(f.ts < win_start || f.ts - win_start < 48'(win_len));
    if (!closed) return;

    total = 64'(counters[wwfa_pkg::EcTotal]);
    if (total == '0) begin
      mean = '0;
    end else begin
      half = total / 2;
      mean = (len_sum + half < len_sum) ? '1 : len_sum + half;
      mean = mean / total;
    end
    vals[wwfa_pkg::FeatTotal] = 64'(counters[wwfa_pkg::EcTotal]);
    vals[wwfa_pkg::FeatBeacon] = 64'(counters[wwfa_pkg::EcBeacon]);
    vals[wwfa_pkg::FeatDeauth] = 64'(counters[wwfa_pkg::EcDeauth]);
    vals[wwfa_pkg::FeatTarget] = 64'(counters[wwfa_pkg::EcTarget]);
    vals[wwfa_pkg::FeatProbe] = 64'(counters[wwfa_pkg::EcProbe]);
    vals[wwfa_pkg::FeatAuth] = 64'(counters[wwfa_pkg::EcAuth]);
    vals[wwfa_pkg::FeatJump] = 64'(counters[wwfa_pkg::EcJump]);
    vals[wwfa_pkg::FeatMgmt] = 64'(counters[wwfa_pkg::EcMgmt]);
    vals[wwfa_pkg::FeatData] = 64'(counters[wwfa_pkg::EcData]);
    vals[wwfa_pkg::FeatCtrl] = 64'(counters[wwfa_pkg::EcCtrl]);
    vals[wwfa_pkg::FeatBytes] = 64'(bytes_all);
    vals[wwfa_pkg::FeatMgmtB] = 64'(bytes_mgmt);
    vals[wwfa_pkg::FeatDataB] = 64'(bytes_data);
    vals[wwfa_pkg::FeatMean] = mean;
    vals[wwfa_pkg::FeatMaxLen] = 64'(len_max);
    vals[wwfa_pkg::FeatLenSum] = len_sum;
    vals[wwfa_pkg::FeatRssiSum] = rssi_sum;
    vals[wwfa_pkg::FeatSnrSum] = snr_sum;
    vals[wwfa_pkg::FeatRssiSq] = rssi_sq_sum;
    vals[wwfa_pkg::FeatBssidCnt] = 64'(seen_cnt);
    vals[wwfa_pkg::FeatTwinCnt] = 64'(twin_cnt);
    vals[wwfa_pkg::FeatRogue] = 64'(rogue_hit);
    for (int k = 0; k < NumFeat; k++) begin
      ft.id = 5'(k);
      ft.value = vals[k];
      ft.last = (k == NumFeat - 1);
      feature_q.push_back(ft);
    end
    win_start = f.ts;
    clear_window_state();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    feature_t e;
    if (!rst && pop && !empty) begin
      if (feature_q.size() == 0) begin
        report_mismatch("unexpected transaction, id", 64'(feature_id), '0);
      end else begin
        e = feature_q.pop_front();
        if (feature_id !== e.id) report_mismatch("feature_id", 64'(feature_id), 64'(e.id));
        if (feature_value !== e.value)
          report_mismatch($sformatf("feature_value of id %0d", e.id), feature_value, e.value);
        if (last_feature !== e.last)
          report_mismatch("last_feature", 64'(last_feature), 64'(e.last));
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_frame(input frame_t f, output bit closed);
    push <= 1'b1;
    timestamp_us <= f.ts;
    frame_class <= f.cls;
    subtype_class <= f.sub;
    frame_length <= f.len;
    rssi_dbm <= f.rssi;
    snr_db <= f.snr;
    frame_bssid <= f.bssid;
    ssid_is_ours <= f.ours;
    targeted_deauth <= f.tgt;
    sequence_jump <= f.jump;
    do @(posedge clk); while (full);
    count_frame(f, closed);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      AddrWinLen: win_len = data[23:0];
      AddrOwnAp: own_ap = data[47:0];
      AddrRogue: rogue_id = data[47:0];
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input logic [3:0] base_top);
    frame_t f;
    bit closed;
    logic [47:0] now;
    logic [23:0] step_max;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    bssid_pool[0] = own_ap;
    bssid_pool[1] = rogue_id;
    bssid_pool[2] = '0;
    for (int i = 3; i < 12; i++) bssid_pool[i] = rand48();
    now = {base_top, 4'($urandom), 40'(rand48())};
    for (int i = 0; i < n; i++) begin
      step_max = ($urandom_range(0, 3) == 0) ? win_len : win_len / 16;
      now = now + 48'($urandom_range(0, int'(step_max)));
      f.ts = now;
      if ($urandom_range(0, 9) == 0) f.ts = now - 48'($urandom_range(1, 1000000));
      f.cls = 2'($urandom);
      f.sub = 3'($urandom);
      case ($urandom_range(0, 5))
        0: f.len = '0;
        1: f.len = '1;
        default: f.len = 16'($urandom);
      endcase
      f.rssi = 8'($urandom);
      f.snr = 8'($urandom);
      f.bssid = ($urandom_range(0, 7) == 0) ? rand48() : bssid_pool[$urandom_range(0, 11)];
      f.ours = 1'($urandom);
      f.tgt = 1'($urandom);
      f.jump = 1'($urandom);
      send_frame(f, closed);
    end
    wait_idle();
  endtask

  row_t rows [$];

  initial begin
    bit closed;
    clear_window_state();
    rows = '{
      '{'{48'd0, 2'd0, 3'd0, 16'd0, -8'sd128, -8'sd128, 48'd0, 1'b0, 1'b0, 1'b0}, 1'b0, 32'd0},
      '{'{48'd5, wwfa_pkg::ClsMgmt, wwfa_pkg::SubBeacon, 16'hFFFF, 8'sd127, 8'sd127,
          wwfa_pkg::RogueReset, 1'b1, 1'b1, 1'b1}, 1'b0, 32'd0},
      '{'{48'd9, wwfa_pkg::ClsData, wwfa_pkg::SubDeauth, 16'd1500, -8'sd40, 8'sd20,
          48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0}, 1'b0, 32'd0},
      '{'{48'd77, wwfa_pkg::ClsCtrl, wwfa_pkg::SubDisassoc, 16'd14, -8'sd1, 8'sd0,
          48'h0000_0000_0001, 1'b1, 1'b0, 1'b1}, 1'b0, 32'd0},
      '{'{48'd500, wwfa_pkg::ClsMgmt, wwfa_pkg::SubProbe, 16'd60, -8'sd70, 8'sd30,
          48'hAAAA_5555_AAAA, 1'b0, 1'b0, 1'b0}, 1'b0, 32'd0},
      '{'{48'd600, wwfa_pkg::ClsMgmt, wwfa_pkg::SubAuth, 16'd30, -8'sd60, 8'sd25,
          48'h5555_AAAA_5555, 1'b1, 1'b0, 1'b0}, 1'b0, 32'd0},
      '{'{48'd700, wwfa_pkg::ClsData, 3'd6, 16'd1, 8'sd5, -8'sd5, 48'h0000_0000_0001,
          1'b0, 1'b0, 1'b1}, 1'b0, 32'd0},
      '{'{48'd99999, wwfa_pkg::ClsCtrl, 3'd7, 16'd2, 8'sd0, -8'sd1, 48'd0, 1'b0, 1'b1,
          1'b0}, 1'b0, 32'd0},
      '{'{48'd100000, wwfa_pkg::ClsMgmt, wwfa_pkg::SubBeacon, 16'd100, -8'sd50, 8'sd10,
          wwfa_pkg::RogueReset, 1'b1, 1'b0, 1'b0}, 1'b1, 32'd9},
      '{'{48'd99999, wwfa_pkg::ClsData, 3'd0, 16'd10, -8'sd50, 8'sd10, 48'd7, 1'b0, 1'b0,
          1'b0}, 1'b0, 32'd0},
      '{'{48'd199999, wwfa_pkg::ClsData, 3'd0, 16'd10, -8'sd50, 8'sd10, 48'd7, 1'b0, 1'b0,
          1'b0}, 1'b0, 32'd0},
      '{'{48'd200000, wwfa_pkg::ClsCtrl, 3'd0, 16'd11, -8'sd30, 8'sd15, 48'd8, 1'b0, 1'b0,
          1'b0}, 1'b1, 32'd3}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_frame(rows[i].f, closed);
      if (closed != rows[i].closes)
        report_mismatch($sformatf("window close of row %0d", i), 64'(closed),
                        64'(rows[i].closes));
      else if (closed && feature_q[feature_q.size() - NumFeat].value != 64'(rows[i].frames))
        report_mismatch($sformatf("frame count of row %0d", i),
                        feature_q[feature_q.size() - NumFeat].value, 64'(rows[i].frames));
    end
    wait_idle();

    reg_write(AddrWinLen, 64'd0);
    reg_write(AddrOwnAp, 64'(rand48()));
    reg_write(AddrRogue, 64'd0);
    run_phase(70, 0, 0, 4'h3);

    reg_write(AddrWinLen, 64'd1);
    reg_write(AddrOwnAp, 64'hFFFF_FFFF_FFFF);
    reg_write(AddrRogue, 64'hFFFF_FFFF_FFFF);
    run_phase(70, 51, 0, 4'h6);

    reg_write(AddrWinLen, 64'hFF_FFFF);
    reg_write(AddrOwnAp, 64'(rand48()));
    reg_write(AddrRogue, 64'(rand48()));
    run_phase(70, 0, 51, 4'h9);

    reg_write(AddrWinLen, 64'($urandom_range(50, 5000)));
    reg_write(AddrOwnAp, 64'(rand48()));
    reg_write(AddrRogue, 64'(rand48()));
    run_phase(70, 38, 38, 4'hC);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/wwfa_pkg.sv
hdl/wwfa_front.sv
hdl/wwfa_div.sv
hdl/wwfa_back.sv
hdl/wifi_window_feature_aggregator_top.sv
verif/testbench.sv
